// ===== rtl/gtl_pkg.sv =====
package gtl_pkg;

  // command codes handed to the drawer
  typedef enum logic [2:0] {
    ACT_NONE  = 3'd0,
    ACT_CHAR  = 3'd1,
    ACT_GLYPH = 3'd2,
    ACT_BLANK = 3'd3,
    ACT_STOP  = 3'd4
  } action_t;

  // register map, word index on the APB port
  localparam logic [2:0] REG_ORIGIN_X    = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y    = 3'd1;
  localparam logic [2:0] REG_AREA_WIDTH  = 3'd2;
  localparam logic [2:0] REG_AREA_HEIGHT = 3'd3;
  localparam logic [2:0] REG_FONT_SIZE   = 3'd4;
  localparam logic [2:0] REG_OVERLAY     = 3'd5;

  // byte codes
  localparam logic [7:0] LEAD_MIN      = 8'h81;
  localparam logic [7:0] TRAIL_MIN     = 8'h40;
  localparam logic [7:0] CODE_FF       = 8'hff;
  localparam logic [7:0] TRAIL_GAP     = 8'h7f;
  localparam logic [7:0] TRAIL_HI_BASE = 8'h41;
  localparam logic [7:0] ASCII_MAX     = 8'h80;
  localparam logic [7:0] CODE_CR       = 8'd13;
  localparam logic [7:0] CODE_END      = 8'd0;
  localparam int         ROW_CODES     = 190;

  typedef struct packed {
    logic [15:0] origin_x;
    logic [15:0] origin_y;
    logic [15:0] area_width;
    logic [15:0] area_height;
    logic [6:0]  font_size;
    logic        overlay_mode;
  } cfg_t;

  typedef enum logic {
    ST_TAKE,
    ST_MUL
  } state_t;

  typedef struct packed {
    logic take;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

  // bitmap bytes per glyph; zero for sizes without a font file
  function automatic logic [9:0] glyph_bytes_of(input logic [6:0] size);
    logic [9:0] r;
    r = 10'd0;
    case (size)
      7'd12:   r = 10'd24;
      7'd16:   r = 10'd32;
      7'd24:   r = 10'd72;
      default: r = 10'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/gtl_if.sv =====
interface gtl_byte_if;
  logic       valid;
  logic       ready;
  logic       start_string;
  logic [7:0] code_byte;

  modport source(output valid, output start_string, output code_byte, input ready);
  modport sink(input valid, input start_string, input code_byte, output ready);
endinterface

interface gtl_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [15:0] pos_x;
  logic [15:0] pos_y;
  logic [7:0]  char_code;
  logic [20:0] glyph_offset;
  logic [9:0]  glyph_bytes;
  logic        overlay;

  modport source(output valid, output action, output pos_x, output pos_y,
                 output char_code, output glyph_offset, output glyph_bytes,
                 output overlay, input ready);
  modport sink(input valid, input action, input pos_x, input pos_y,
               input char_code, input glyph_offset, input glyph_bytes,
               input overlay, output ready);
endinterface

// ===== rtl/gtl_ctrl.sv =====
module gtl_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  gtl_pkg::status_t status,
  output gtl_pkg::cmd_t    cmd
);
  import gtl_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_TAKE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_TAKE: if (in_valid) state_next = ST_MUL;
      ST_MUL:  if (status.out_free) state_next = ST_TAKE;
      default: state_next = ST_TAKE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state)
      ST_TAKE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      ST_MUL: begin
        cmd.load = status.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/gtl_datapath.sv =====
module gtl_datapath (
  input  logic             clk,
  input  logic             rst,
  input  gtl_pkg::cfg_t    cfg,
  input  gtl_pkg::cmd_t    cmd,
  output gtl_pkg::status_t status,
  input  logic             start_string,
  input  logic [7:0]       code_byte,
  gtl_cmd_if.source        cmd_out
);
  import gtl_pkg::*;

  // text state
  logic [15:0] cursor_x, cursor_y;
  logic [7:0]  lead_byte;
  logic        lead_pending, skip_next, finished;

  logic [15:0] cursor_x_next, cursor_y_next;
  logic [7:0]  lead_byte_next;
  logic        lead_pending_next, skip_next_next, finished_next;

  // result held between the step and the multiply
  action_t     p_action, p_action_next;
  logic [15:0] p_x, p_x_next, p_y, p_y_next;
  logic [7:0]  p_char, p_char_next;
  logic [9:0]  p_bytes, p_bytes_next;
  logic [14:0] p_idx, p_idx_next;

  logic        out_valid;

  // cursor after an optional start of string
  logic [15:0] cx, cy;
  logic        lp, sk, fin;
  logic [15:0] fs16, half, cell_w;
  logic signed [18:0] lim_x, lim_y;
  logic        wrap, below;
  logic [15:0] cx_w, cy_w;

  // glyph addressing
  logic        code_bad;
  logic [6:0]  qh;
  logic [7:0]  ql;
  logic [14:0] row_base, glyph_idx;
  logic [9:0]  csize;

  assign cx  = start_string ? cfg.origin_x : cursor_x;
  assign cy  = start_string ? cfg.origin_y : cursor_y;
  assign lp  = start_string ? 1'b0 : lead_pending;
  assign sk  = start_string ? 1'b0 : skip_next;
  assign fin = start_string ? 1'b0 : finished;

  assign fs16   = {9'd0, cfg.font_size};
  assign half   = {10'd0, cfg.font_size[6:1]};
  assign cell_w = lp ? fs16 : half;

  // right-edge test, wide enough never to wrap
  assign lim_x = $signed({3'b000, cfg.origin_x}) + $signed({3'b000, cfg.area_width})
               - $signed({3'b000, cell_w});
  assign wrap  = $signed({3'b000, cx}) > lim_x;
  assign cx_w  = wrap ? cfg.origin_x : cx;
  assign cy_w  = wrap ? cy + fs16 : cy;

  assign lim_y = $signed({3'b000, cfg.origin_y}) + $signed({3'b000, cfg.area_height})
               - $signed({12'd0, cfg.font_size});
  assign below = $signed({3'b000, cy_w}) > lim_y;

  assign csize    = glyph_bytes_of(cfg.font_size);
  assign code_bad = (lead_byte < LEAD_MIN) || (code_byte < TRAIL_MIN)
                 || (code_byte == CODE_FF) || (lead_byte == CODE_FF);
  assign qh       = 7'(lead_byte - LEAD_MIN);
  assign ql       = (code_byte < TRAIL_GAP) ? code_byte - TRAIL_MIN
                                            : code_byte - TRAIL_HI_BASE;
  assign row_base = {8'd0, qh} * 15'(ROW_CODES);
  assign glyph_idx = row_base + {7'd0, ql};

  always_comb begin
    cursor_x_next     = cx;
    cursor_y_next     = cy;
    lead_byte_next    = lead_byte;
    lead_pending_next = lp;
    skip_next_next    = sk;
    finished_next     = fin;
    p_action_next     = ACT_NONE;
    p_x_next          = 16'd0;
    p_y_next          = 16'd0;
    p_char_next       = 8'd0;
    p_bytes_next      = 10'd0;
    p_idx_next        = 15'd0;

    if (fin) begin
      finished_next = 1'b1;
    end else if (sk) begin
      skip_next_next = 1'b0;
      if (code_byte == CODE_END) finished_next = 1'b1;
    end else if (lp) begin
      lead_pending_next = 1'b0;
      cursor_x_next     = cx_w;
      cursor_y_next     = cy_w;
      if (below) begin
        finished_next = 1'b1;
        p_action_next = ACT_STOP;
        p_x_next      = cx_w;
        p_y_next      = cy_w;
      end else begin
        if (csize != 10'd0) begin
          p_x_next     = cx_w;
          p_y_next     = cy_w;
          p_bytes_next = csize;
          if (code_bad) begin
            p_action_next = ACT_BLANK;
          end else begin
            p_action_next = ACT_GLYPH;
            p_idx_next    = glyph_idx;
          end
        end
        cursor_x_next = cx_w + fs16;
        if (code_byte == CODE_END) finished_next = 1'b1;
      end
    end else if (code_byte == CODE_END) begin
      finished_next = 1'b1;
    end else if (code_byte > ASCII_MAX) begin
      lead_byte_next    = code_byte;
      lead_pending_next = 1'b1;
    end else begin
      cursor_x_next = cx_w;
      cursor_y_next = cy_w;
      if (below) begin
        finished_next = 1'b1;
        p_action_next = ACT_STOP;
        p_x_next      = cx_w;
        p_y_next      = cy_w;
      end else if (code_byte == CODE_CR) begin
        // new line, x indented by half a cell, next byte dropped
        cursor_y_next  = cy_w + fs16;
        cursor_x_next  = cfg.origin_x + half;
        skip_next_next = 1'b1;
      end else begin
        p_action_next = ACT_CHAR;
        p_x_next      = cx_w;
        p_y_next      = cy_w;
        p_char_next   = code_byte;
        cursor_x_next = cx_w + half;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x     <= 16'd0;
      cursor_y     <= 16'd0;
      lead_byte    <= 8'd0;
      lead_pending <= 1'b0;
      skip_next    <= 1'b0;
      finished     <= 1'b0;
    end else if (cmd.take) begin
      cursor_x     <= cursor_x_next;
      cursor_y     <= cursor_y_next;
      lead_byte    <= lead_byte_next;
      lead_pending <= lead_pending_next;
      skip_next    <= skip_next_next;
      finished     <= finished_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      p_action <= p_action_next;
      p_x      <= p_x_next;
      p_y      <= p_y_next;
      p_char   <= p_char_next;
      p_bytes  <= p_bytes_next;
      p_idx    <= p_idx_next;
    end
  end

  // output register
  assign status.out_free = !out_valid || cmd_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (cmd_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_out.action       <= p_action;
      cmd_out.pos_x        <= p_x;
      cmd_out.pos_y        <= p_y;
      cmd_out.char_code    <= p_char;
      cmd_out.glyph_bytes  <= p_bytes;
      cmd_out.glyph_offset <= 21'({10'd0, p_idx} * {15'd0, p_bytes});
      cmd_out.overlay      <= cfg.overlay_mode;
    end
  end

  assign cmd_out.valid = out_valid;

endmodule

// ===== rtl/gbk_text_layout_glyph_addresser_unit.sv =====
// GBK text layout and glyph addresser.
// byte_in (valid/ready): one string byte per request, with start_string to
//   home the cursor to the origin and clear the pending lead, skip and stop
//   flags before the byte is used.
// cmd_out (valid/ready): one drawer command per accepted byte: nothing, ASCII
//   char, glyph at a font-file byte offset, blank glyph, or stopped.
// APB port: six word registers at byte address 4*i (origin x/y, area
//   width/height, font size, overlay mode); pready is tied high, reads return
//   the register. Write only while no byte is in flight.
// Steps: a taken byte gets its cursor step, wrap and bottom tests and glyph
//   row index, all registered; the multiply step then multiplies the index
//   by the glyph size and loads the output register once it is free, which
//   raises cmd_out.valid. A new byte is taken only after that load, as the
//   sequencer waits in the multiply step and each byte moves the cursor.
// Reset: registers go to their defaults (area 240x320, size 16), cursor to
//   zero, no command pending.
// Stall: the output register holds its command while cmd_out.ready is low;
//   a second byte may be taken meanwhile, then byte_in.ready drops until the
//   held command is taken.
module gbk_text_layout_glyph_addresser_unit (
  input  logic        clk,
  input  logic        rst,
  gtl_byte_if.sink    byte_in,
  gtl_cmd_if.source   cmd_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import gtl_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;
  logic    cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  // configuration registers; word index from paddr[4:2]
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_x     <= 16'd0;
      cfg.origin_y     <= 16'd0;
      cfg.area_width   <= 16'd240;
      cfg.area_height  <= 16'd320;
      cfg.font_size    <= 7'd16;
      cfg.overlay_mode <= 1'b0;
    end else if (cfg_write) begin
      unique case (paddr[4:2])
        REG_ORIGIN_X:    cfg.origin_x     <= pwdata[15:0];
        REG_ORIGIN_Y:    cfg.origin_y     <= pwdata[15:0];
        REG_AREA_WIDTH:  cfg.area_width   <= pwdata[15:0];
        REG_AREA_HEIGHT: cfg.area_height  <= pwdata[15:0];
        REG_FONT_SIZE:   cfg.font_size    <= pwdata[6:0];
        REG_OVERLAY:     cfg.overlay_mode <= pwdata[0];
        default: ;  // unmapped words ignore writes
      endcase
    end
  end

  // read-back mux
  always_comb begin
    unique case (paddr[4:2])
      REG_ORIGIN_X:    prdata = {16'd0, cfg.origin_x};
      REG_ORIGIN_Y:    prdata = {16'd0, cfg.origin_y};
      REG_AREA_WIDTH:  prdata = {16'd0, cfg.area_width};
      REG_AREA_HEIGHT: prdata = {16'd0, cfg.area_height};
      REG_FONT_SIZE:   prdata = {25'd0, cfg.font_size};
      REG_OVERLAY:     prdata = {31'd0, cfg.overlay_mode};
      default:         prdata = 32'd0;
    endcase
  end

  // sequencer: take a byte, then multiply and load the output
  gtl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (byte_in.valid),
    .in_ready (byte_in.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // cursor state, step logic, glyph addressing and output register
  gtl_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd          (cmd),
    .status       (status),
    .start_string (byte_in.start_string),
    .code_byte    (byte_in.code_byte),
    .cmd_out      (cmd_out)
  );

endmodule

// ===== dv/gtl_layout_checker.sv =====
`timescale 1ns / 1ps
module gtl_layout_checker (
  input  logic        clk,
  input  logic        rst,
  gtl_byte_if         byte_mon,
  gtl_cmd_if          cmd_mon,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output int          mismatches,
  output int          draws_owed
);
  import gtl_pkg::*;

  typedef struct packed {
    action_t     action;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [7:0]  char_code;
    logic [20:0] glyph_offset;
    logic [9:0]  glyph_bytes;
    logic        overlay;
  } draw_cmd_t;

  // register shadow
  logic [15:0] org_x, org_y, area_w, area_h;
  logic [6:0]  cell_h;
  logic        ovl;

  // layout state
  logic [15:0] cur_x, cur_y;
  logic [7:0]  lead;
  logic        lead_held, skip_byte, done;

  draw_cmd_t   pending_draws[$];
  int          errs;

  function automatic void wrap_to_fit(input logic [6:0] cell_w);
    int limit;
    limit = int'(org_x) + int'(area_w) - int'(cell_w);
    if (int'(cur_x) > limit) begin
      cur_y = cur_y + cell_h;
      cur_x = org_x;
    end
  endfunction

  function automatic bit past_bottom();
    return int'(cur_y) > int'(org_y) + int'(area_h) - int'(cell_h);
  endfunction

  function automatic draw_cmd_t predict_draw_cmd(input logic start, input logic [7:0] b);
    draw_cmd_t c;
    logic [6:0] half;
    int row, col, nbytes, offs;
    c.action       = ACT_NONE;
    c.pos_x        = '0;
    c.pos_y        = '0;
    c.char_code    = '0;
    c.glyph_offset = '0;
    c.glyph_bytes  = '0;
    c.overlay      = ovl;
    half = cell_h >> 1;

    if (start) begin
      cur_x     = org_x;
      cur_y     = org_y;
      lead_held = 1'b0;
      skip_byte = 1'b0;
      done      = 1'b0;
    end
    if (done) return c;

    if (skip_byte) begin
      skip_byte = 1'b0;
      if (b == CODE_END) done = 1'b1;
      return c;
    end

    if (lead_held) begin
      lead_held = 1'b0;
      wrap_to_fit(cell_h);
      if (past_bottom()) begin
        done     = 1'b1;
        c.action = ACT_STOP;
        c.pos_x  = cur_x;
        c.pos_y  = cur_y;
        return c;
      end
      // font files exist for 12, 16 and 24 only
      if (cell_h == 7'd12 || cell_h == 7'd16 || cell_h == 7'd24) begin
        nbytes = ((int'(cell_h) + 7) / 8) * int'(cell_h);
        c.pos_x       = cur_x;
        c.pos_y       = cur_y;
        c.glyph_bytes = nbytes[9:0];
        if (lead < LEAD_MIN || b < TRAIL_MIN || b == CODE_FF || lead == CODE_FF) begin
          c.action = ACT_BLANK;
        end else begin
          col  = (b < TRAIL_GAP) ? int'(b) - int'(TRAIL_MIN) : int'(b) - int'(TRAIL_HI_BASE);
          row  = int'(lead) - int'(LEAD_MIN);
          offs = (ROW_CODES * row + col) * nbytes;
          c.action       = ACT_GLYPH;
          c.glyph_offset = offs[20:0];
        end
      end
      cur_x = cur_x + cell_h;
      if (b == CODE_END) done = 1'b1;
      return c;
    end

    if (b == CODE_END) begin
      done = 1'b1;
      return c;
    end
    if (b > ASCII_MAX) begin
      lead      = b;
      lead_held = 1'b1;
      return c;
    end

    wrap_to_fit(half);
    if (past_bottom()) begin
      done      = 1'b1;
      lead_held = 1'b0;
      c.action  = ACT_STOP;
      c.pos_x   = cur_x;
      c.pos_y   = cur_y;
      return c;
    end
    if (b == CODE_CR) begin
      cur_y     = cur_y + cell_h;
      cur_x     = org_x;
      skip_byte = 1'b1;
    end else begin
      c.action    = ACT_CHAR;
      c.pos_x     = cur_x;
      c.pos_y     = cur_y;
      c.char_code = b;
    end
    cur_x = cur_x + half;
    return c;
  endfunction

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    draw_cmd_t want;
    if (rst) begin
      org_x     = '0;
      org_y     = '0;
      area_w    = 16'd240;
      area_h    = 16'd320;
      cell_h    = 7'd16;
      ovl       = 1'b0;
      cur_x     = '0;
      cur_y     = '0;
      lead      = '0;
      lead_held = 1'b0;
      skip_byte = 1'b0;
      done      = 1'b0;
      pending_draws.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_ORIGIN_X:    org_x  = pwdata[15:0];
          REG_ORIGIN_Y:    org_y  = pwdata[15:0];
          REG_AREA_WIDTH:  area_w = pwdata[15:0];
          REG_AREA_HEIGHT: area_h = pwdata[15:0];
          REG_FONT_SIZE:   cell_h = pwdata[6:0];
          REG_OVERLAY:     ovl    = pwdata[0];
          default: ;
        endcase
      end
      if (cmd_mon.valid && cmd_mon.ready) begin
        if (pending_draws.size() == 0) begin
          $error("command with no byte request outstanding");
          errs++;
        end else begin
          want = pending_draws.pop_front();
          check_field("action", 32'(cmd_mon.action), 32'(want.action));
          check_field("pos_x", 32'(cmd_mon.pos_x), 32'(want.pos_x));
          check_field("pos_y", 32'(cmd_mon.pos_y), 32'(want.pos_y));
          check_field("char_code", 32'(cmd_mon.char_code), 32'(want.char_code));
          check_field("glyph_offset", 32'(cmd_mon.glyph_offset), 32'(want.glyph_offset));
          check_field("glyph_bytes", 32'(cmd_mon.glyph_bytes), 32'(want.glyph_bytes));
          check_field("overlay", 32'(cmd_mon.overlay), 32'(want.overlay));
        end
      end
      if (byte_mon.valid && byte_mon.ready)
        pending_draws.push_back(predict_draw_cmd(byte_mon.start_string, byte_mon.code_byte));
    end
    mismatches <= errs;
    draws_owed <= pending_draws.size();
  end

endmodule

// ===== dv/tb_gbk_text_layout_glyph_addresser_unit.sv =====
`timescale 1ns / 1ps
module tb_gbk_text_layout_glyph_addresser_unit;
  import gtl_pkg::*;

  // no request moving on any port for this long means the block has hung
  localparam int STALL_LIMIT = 2000;
  // random requests per register setting; nine settings in all
  localparam int PHASE_ITEMS = 200;

  logic        clk;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        cmd_ready;

  int          tx_idle_pct;
  int          rx_idle_pct;
  int          items_sent;
  int          quiet_cycles;
  int          mismatches;
  int          draws_owed;

  gtl_byte_if byte_ch();
  gtl_cmd_if  cmd_ch();

  assign cmd_ch.ready = cmd_ready;

  gbk_text_layout_glyph_addresser_unit u_top (
    .clk     (clk),
    .rst     (rst),
    .byte_in (byte_ch),
    .cmd_out (cmd_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // checker sits beside the block: watches both channels and the APB
  // writes, predicts every command and counts mismatches
  gtl_layout_checker u_chk (
    .clk        (clk),
    .rst        (rst),
    .byte_mon   (byte_ch),
    .cmd_mon    (cmd_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .mismatches (mismatches),
    .draws_owed (draws_owed)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // drawer side: ready dropped at random, per cycle
  always @(posedge clk) begin
    if (rst) begin
      cmd_ready <= 1'b0;
    end else begin
      cmd_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // watchdog: counts cycles in which no request moves anywhere
  always @(posedge clk) begin
    if (rst || psel || (byte_ch.valid && byte_ch.ready) || (cmd_ch.valid && cmd_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL gbk_text_layout_glyph_addresser_unit");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Valid is left high after a request is taken; the next call either keeps
  // it high or drops it for a gap, so it never gets two updates in one step.
  task automatic send_byte(input logic start, input logic [7:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk);
    end
    byte_ch.valid        <= 1'b1;
    byte_ch.start_string <= start;
    byte_ch.code_byte    <= b;
    do @(posedge clk); while (!byte_ch.ready);
    items_sent++;
  endtask

  // stop sending, wait for every predicted command, then a short pause
  // (take and multiply steps plus margin) so nothing is still in flight
  task automatic settle();
    byte_ch.valid <= 1'b0;
    do @(posedge clk); while (draws_owed != 0);
    repeat (6) @(posedge clk);
  endtask

  // setup + access; psel/penable are left for the caller to drop so that
  // back-to-back writes never assign them twice in one step
  task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  // registers only change while the block is idle
  task automatic set_layout(input logic [15:0] ox, input logic [15:0] oy,
                            input logic [15:0] w, input logic [15:0] h,
                            input logic [6:0] fs, input logic ov);
    settle();
    apb_write(REG_ORIGIN_X, 32'(ox));
    apb_write(REG_ORIGIN_Y, 32'(oy));
    apb_write(REG_AREA_WIDTH, 32'(w));
    apb_write(REG_AREA_HEIGHT, 32'(h));
    apb_write(REG_FONT_SIZE, 32'(fs));
    apb_write(REG_OVERLAY, 32'(ov));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // A proper string: start flag on the first byte, a run of ASCII, GBK
  // pairs (mostly valid), carriage returns, then the terminating zero.
  task automatic send_text();
    int   n;
    int   kind;
    logic first;
    n     = $urandom_range(1, 24);
    first = 1'b1;
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(99);
      if (kind < 45) begin
        send_byte(first, 8'($urandom_range(1, 8'h7f)));
      end else if (kind < 80) begin
        send_byte(first, 8'($urandom_range(LEAD_MIN, 8'hfe)));
        send_byte(1'b0, 8'($urandom_range(TRAIL_MIN, 8'hfe)));
      end else if (kind < 88) begin
        // bad pair: lead of ff, or trail below 40 or equal to ff
        case ($urandom_range(2))
          0: begin
            send_byte(first, CODE_FF);
            send_byte(1'b0, 8'($urandom_range(1, 8'hff)));
          end
          1: begin
            send_byte(first, 8'($urandom_range(LEAD_MIN, CODE_FF)));
            send_byte(1'b0, 8'($urandom_range(1, 8'h3f)));
          end
          default: begin
            send_byte(first, 8'($urandom_range(LEAD_MIN, CODE_FF)));
            send_byte(1'b0, CODE_FF);
          end
        endcase
      end else if (kind < 95) begin
        // CR swallows whatever follows, a zero included
        send_byte(first, CODE_CR);
        send_byte(1'b0, 8'($urandom_range(0, 8'hff)));
      end else begin
        send_byte(first, ASCII_MAX);
      end
      first = 1'b0;
    end
    send_byte(first, CODE_END);
  endtask

  // raw bytes, start flag now and then: broken pairs, stray trails, etc.
  task automatic send_noise();
    int n;
    n = $urandom_range(1, 12);
    for (int i = 0; i < n; i++)
      send_byte(($urandom_range(9) == 0), 8'($urandom_range(0, 8'hff)));
  endtask

  initial begin
    logic [15:0] ox, oy, w, h;
    logic [6:0]  fs;
    logic        ov;
    int          phase_start;

    rst                  <= 1'b1;
    psel                 <= 1'b0;
    penable              <= 1'b0;
    pwrite               <= 1'b0;
    paddr                <= '0;
    pwdata               <= '0;
    byte_ch.valid        <= 1'b0;
    byte_ch.start_string <= 1'b0;
    byte_ch.code_byte    <= '0;
    tx_idle_pct          = 17;
    rx_idle_pct          = 46;
    items_sent           = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // ---- directed: reset-style layout 240x320, size 16 ----
    set_layout(16'd0, 16'd0, 16'd240, 16'd320, 7'd16, 1'b0);
    send_byte(1'b1, 8'h41);              // plain ASCII
    send_byte(1'b0, ASCII_MAX);          // 80 counts as ASCII
    send_byte(1'b0, LEAD_MIN);           // first glyph of the font
    send_byte(1'b0, TRAIL_MIN);
    send_byte(1'b0, 8'hfe);              // last valid glyph
    send_byte(1'b0, 8'hfe);
    send_byte(1'b0, LEAD_MIN);           // either side of the 7f gap
    send_byte(1'b0, 8'h7e);
    send_byte(1'b0, LEAD_MIN);
    send_byte(1'b0, 8'h80);
    send_byte(1'b0, CODE_FF);            // lead of ff: blank
    send_byte(1'b0, TRAIL_HI_BASE);
    send_byte(1'b0, LEAD_MIN);           // trail too low: blank
    send_byte(1'b0, 8'h3f);
    send_byte(1'b0, LEAD_MIN);           // trail of ff: blank
    send_byte(1'b0, CODE_FF);
    send_byte(1'b0, CODE_CR);            // CR drops the next byte
    send_byte(1'b0, 8'h42);
    send_byte(1'b0, 8'h43);
    send_byte(1'b0, CODE_CR);            // CR then zero ends the string
    send_byte(1'b0, CODE_END);
    send_byte(1'b0, 8'h44);              // ignored once finished
    send_byte(1'b1, 8'h90);              // zero trail: blank, then ends
    send_byte(1'b0, CODE_END);
    send_byte(1'b1, 8'h7f);

    // size with no font file: pair draws nothing but still moves the cursor
    set_layout(16'd0, 16'd0, 16'd240, 16'd320, 7'd23, 1'b1);
    send_byte(1'b1, 8'hb0);
    send_byte(1'b0, 8'ha1);
    send_byte(1'b0, 8'h41);

    // zero height: first byte stops the string, the rest are dropped
    set_layout(16'd0, 16'd0, 16'd240, 16'd0, 7'd16, 1'b0);
    send_byte(1'b1, 8'h41);
    send_byte(1'b0, 8'h42);

    // ---- random phases, each with its own layout ----
    for (int ph = 0; ph < 9; ph++) begin
      ox = 16'($urandom_range(0, 64));
      oy = 16'($urandom_range(0, 64));
      w  = 16'($urandom_range(40, 320));
      h  = 16'($urandom_range(24, 240));
      case ($urandom_range(2))
        0:       fs = 7'd12;
        1:       fs = 7'd16;
        default: fs = 7'd24;
      endcase
      ov = 1'($urandom_range(1));
      case (ph)
        1: w = 16'd0;                          // wrap before every character
        2: begin
          ox = 16'hffff;                       // origin at the very corner
          oy = 16'hffff;
        end
        4: begin
          w  = 16'hffff;
          h  = 16'hffff;
          fs = 7'd8;
        end
        5: begin
          ox = 16'($urandom);
          oy = 16'($urandom);
          w  = 16'($urandom);
          h  = 16'($urandom);
          fs = 7'($urandom_range(8, 64));
        end
        7: fs = 7'd64;
        8: begin
          ox = 16'($urandom);
          oy = 16'($urandom);
          fs = 7'($urandom_range(8, 64));
        end
        default: ;
      endcase
      set_layout(ox, oy, w, h, fs, ov);

      // idling: sender light / drawer heavy, then swapped, then none
      tx_idle_pct = (ph < 3) ? 17 : (ph < 6) ? 46 : 0;
      rx_idle_pct = (ph < 3) ? 46 : (ph < 6) ? 17 : 0;

      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        if ($urandom_range(99) < 85) send_text();
        else send_noise();
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("PASS gbk_text_layout_glyph_addresser_unit");
    end else begin
      $display("FAIL gbk_text_layout_glyph_addresser_unit");
    end
    $finish;
  end

endmodule
